// ===== hw/rtl/pirp_pkg.sv =====
// Shared types and constants of the protobuf image record parser.
`default_nettype none

package pirp_pkg;

  localparam int OffsetBitsDef = 24;

  // Parser phases
  localparam logic [2:0] PH_TAG   = 3'd0;
  localparam logic [2:0] PH_VALUE = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_ERROR = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_END     = 2'd2;

  // Wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Captured field numbers
  localparam logic [28:0] FN_CHANNELS = 29'd1;
  localparam logic [28:0] FN_HEIGHT   = 29'd2;
  localparam logic [28:0] FN_WIDTH    = 29'd3;
  localparam logic [28:0] FN_LABEL    = 29'd5;

  // One classified record byte as it travels from front to back
  typedef struct packed {
    logic [6:0] data;
    logic       more;
    logic       last;
  } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pirp_if.sv =====
// Stream interfaces for record bytes in and parse results out.
`default_nettype none

interface pirp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_byte;
  logic       last_byte;

  modport source (output valid, record_byte, last_byte, input ready);
  modport sink   (input valid, record_byte, last_byte, output ready);
endinterface

interface pirp_out_if import pirp_pkg::*; #(
  parameter int OFFSET_BITS = OffsetBitsDef
);
  logic                   valid;
  logic                   ready;
  logic [31:0]            channels;
  logic [31:0]            height;
  logic [31:0]            width;
  logic signed [31:0]     label;
  logic [3:0]             found_mask;
  logic [OFFSET_BITS-1:0] payload_offset;
  logic [OFFSET_BITS-1:0] payload_length;
  logic [1:0]             status;

  modport source (output valid, channels, height, width, label, found_mask,
                  payload_offset, payload_length, status, input ready);
  modport sink   (input valid, channels, height, width, label, found_mask,
                  payload_offset, payload_length, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/protobuf_image_record_parser_top.sv =====
// Top level of the protobuf image record parser.
`default_nettype none

// Parses one serialized image record, one byte per beat on rec_i with the
// last byte flagged, and gives one beat on res_o per record: channels,
// height, width and label from varint fields 1, 2, 3 and 5, a found mask,
// the offset and length of the last length-delimited field, and a status
// (ok, unknown wire type, unexpected end). Bytes are taken at one per cycle
// while no last byte is held; each byte passes a two-entry queue and then the
// wire-format state machine, which handles one byte per cycle on the same terms
// and writes a record's result to an output register as its last byte leaves
// the queue. The result sits there, and bytes keep flowing while it waits; only
// the next record's last byte holds until that register is free. res_o must be
// instantiated with the same OFFSET_BITS as this block.
module protobuf_image_record_parser_top import pirp_pkg::*; #(
  parameter int OFFSET_BITS = OffsetBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pirp_in_if.sink   rec_i,
  pirp_out_if.source res_o
);

  item_t                  item;
  logic                   item_valid;
  logic                   item_pop;
  logic [31:0]            label_raw;
  logic [OFFSET_BITS-1:0] poff;
  logic [OFFSET_BITS-1:0] plen;

  pirp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (rec_i.valid),
    .record_byte_i (rec_i.record_byte),
    .last_byte_i   (rec_i.last_byte),
    .ready_o       (rec_i.ready),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_pop_i    (item_pop)
  );

  pirp_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item),
    .item_valid_i     (item_valid),
    .item_pop_o       (item_pop),
    .res_valid_o      (res_o.valid),
    .res_ready_i      (res_o.ready),
    .channels_o       (res_o.channels),
    .height_o         (res_o.height),
    .width_o          (res_o.width),
    .label_o          (label_raw),
    .found_mask_o     (res_o.found_mask),
    .payload_offset_o (poff),
    .payload_length_o (plen),
    .status_o         (res_o.status)
  );

  assign res_o.label          = $signed(label_raw);
  assign res_o.payload_offset = poff;
  assign res_o.payload_length = plen;

endmodule

`default_nettype wire

// ===== hw/rtl/pirp_front.sv =====
// Front end: accepts record bytes, splits each into seven data bits and a continuation flag, and queues them.
`default_nettype none

module pirp_front import pirp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] record_byte_i,
  input  wire logic       last_byte_i,
  output      logic       ready_o,
  output      item_t      item_o,
  output      logic       item_valid_o,
  input  wire logic       item_pop_i
);

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  item_t      item_in;

  assign ready_o      = (count_q != 2'd2);
  assign push         = valid_i && ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    item_in.data = record_byte_i[6:0];
    item_in.more = record_byte_i[7];
    item_in.last = last_byte_i;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = item_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, item_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pirp_back.sv =====
// Back end: wire-format state machine, field capture and result register.
`default_nettype none

module pirp_back import pirp_pkg::*; #(
  parameter int OFFSET_BITS = OffsetBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire item_t                  item_i,
  input  wire logic                   item_valid_i,
  output      logic                   item_pop_o,
  output      logic                   res_valid_o,
  input  wire logic                   res_ready_i,
  output      logic [31:0]            channels_o,
  output      logic [31:0]            height_o,
  output      logic [31:0]            width_o,
  output      logic [31:0]            label_o,
  output      logic [3:0]             found_mask_o,
  output      logic [OFFSET_BITS-1:0] payload_offset_o,
  output      logic [OFFSET_BITS-1:0] payload_length_o,
  output      logic [1:0]             status_o
);

  localparam logic [OFFSET_BITS-1:0] PosMax = '1;

  logic [2:0]             phase_q, phase_d;
  logic [63:0]            acc_q, acc_d;
  logic [6:0]             shift_q, shift_d;
  logic [28:0]            field_q, field_d;
  logic [OFFSET_BITS-1:0] skip_q, skip_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [31:0]            chan_q, chan_d;
  logic [31:0]            hgt_q, hgt_d;
  logic [31:0]            wid_q, wid_d;
  logic [31:0]            lab_q, lab_d;
  logic [3:0]             seen_q, seen_d;
  logic [OFFSET_BITS-1:0] pstart_q, pstart_d;
  logic [OFFSET_BITS-1:0] psize_q, psize_d;
  logic                   pseen_q, pseen_d;
  logic [1:0]             err_q, err_d;

  logic                   out_valid_q;
  logic [1:0]             status_d;
  logic [63:0]            acc_or;
  logic [6:0]             shift_inc;
  logic [OFFSET_BITS-1:0] next_pos;
  logic [OFFSET_BITS-1:0] len_sat;
  logic                   out_free;

  // Hold a last byte back until the result register can take its beat
  assign out_free   = !out_valid_q || res_ready_i;
  assign item_pop_o = item_valid_i && (!item_i.last || out_free);

  always_comb begin
    acc_or    = acc_q;
    if (shift_q < 7'd64) begin
      acc_or = acc_q | ({57'd0, item_i.data} << shift_q[5:0]);
    end
    shift_inc = (shift_q < 7'd70) ? shift_q + 7'd7 : shift_q;
    next_pos  = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
    len_sat   = (|acc_or[63:OFFSET_BITS]) ? PosMax : acc_or[OFFSET_BITS-1:0];

    phase_d  = phase_q;
    acc_d    = acc_q;
    shift_d  = shift_q;
    field_d  = field_q;
    skip_d   = skip_q;
    chan_d   = chan_q;
    hgt_d    = hgt_q;
    wid_d    = wid_q;
    lab_d    = lab_q;
    seen_d   = seen_q;
    pstart_d = pstart_q;
    psize_d  = psize_q;
    pseen_d  = pseen_q;
    err_d    = err_q;
    pos_d    = next_pos;

    case (phase_q)
      PH_TAG: begin
        acc_d   = acc_or;
        shift_d = shift_inc;
        if (!item_i.more) begin
          acc_d   = '0;
          shift_d = '0;
          field_d = acc_or[31:3];
          case (acc_or[2:0])
            WT_VARINT: phase_d = PH_VALUE;
            WT_FIXED64: begin
              skip_d  = OFFSET_BITS'(8);
              phase_d = PH_SKIP;
            end
            WT_FIXED32: begin
              skip_d  = OFFSET_BITS'(4);
              phase_d = PH_SKIP;
            end
            WT_LEN: phase_d = PH_LEN;
            default: begin
              err_d   = ST_UNKNOWN;
              phase_d = PH_ERROR;
            end
          endcase
        end
      end
      PH_VALUE: begin
        acc_d   = acc_or;
        shift_d = shift_inc;
        if (!item_i.more) begin
          acc_d   = '0;
          shift_d = '0;
          phase_d = PH_TAG;
          if (field_q == FN_CHANNELS) begin
            chan_d    = acc_or[31:0];
            seen_d[0] = 1'b1;
          end else if (field_q == FN_HEIGHT) begin
            hgt_d     = acc_or[31:0];
            seen_d[1] = 1'b1;
          end else if (field_q == FN_WIDTH) begin
            wid_d     = acc_or[31:0];
            seen_d[2] = 1'b1;
          end else if (field_q == FN_LABEL) begin
            lab_d     = acc_or[31:0];
            seen_d[3] = 1'b1;
          end
        end
      end
      PH_LEN: begin
        acc_d   = acc_or;
        shift_d = shift_inc;
        if (!item_i.more) begin
          acc_d    = '0;
          shift_d  = '0;
          pstart_d = next_pos;
          psize_d  = len_sat;
          pseen_d  = 1'b1;
          if (len_sat == '0) begin
            phase_d = PH_TAG;
          end else begin
            skip_d  = len_sat;
            phase_d = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        // skip count is never zero while in this phase
        skip_d = skip_q - 1'b1;
        if (skip_q == OFFSET_BITS'(1)) begin
          phase_d = PH_TAG;
        end
      end
      default: begin
      end
    endcase

    if (err_d == ST_UNKNOWN) begin
      status_d = ST_UNKNOWN;
    end else if (phase_d != PH_TAG || !pseen_d) begin
      status_d = ST_END;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG;
      acc_q    <= '0;
      shift_q  <= '0;
      field_q  <= '0;
      skip_q   <= '0;
      pos_q    <= '0;
      chan_q   <= '0;
      hgt_q    <= '0;
      wid_q    <= '0;
      lab_q    <= '0;
      seen_q   <= '0;
      pstart_q <= '0;
      psize_q  <= '0;
      pseen_q  <= 1'b0;
      err_q    <= ST_OK;
    end else if (item_pop_o) begin
      if (item_i.last) begin
        // record done: start the next one from a clean state
        phase_q  <= PH_TAG;
        acc_q    <= '0;
        shift_q  <= '0;
        field_q  <= '0;
        skip_q   <= '0;
        pos_q    <= '0;
        chan_q   <= '0;
        hgt_q    <= '0;
        wid_q    <= '0;
        lab_q    <= '0;
        seen_q   <= '0;
        pstart_q <= '0;
        psize_q  <= '0;
        pseen_q  <= 1'b0;
        err_q    <= ST_OK;
      end else begin
        phase_q  <= phase_d;
        acc_q    <= acc_d;
        shift_q  <= shift_d;
        field_q  <= field_d;
        skip_q   <= skip_d;
        pos_q    <= pos_d;
        chan_q   <= chan_d;
        hgt_q    <= hgt_d;
        wid_q    <= wid_d;
        lab_q    <= lab_d;
        seen_q   <= seen_d;
        pstart_q <= pstart_d;
        psize_q  <= psize_d;
        pseen_q  <= pseen_d;
        err_q    <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_pop_o && item_i.last) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o && item_i.last) begin
      channels_o       <= chan_d;
      height_o         <= hgt_d;
      width_o          <= wid_d;
      label_o          <= lab_d;
      found_mask_o     <= seen_d;
      payload_offset_o <= pstart_d;
      payload_length_o <= psize_d;
      status_o         <= status_d;
    end
  end

  assign res_valid_o = out_valid_q;

endmodule

`default_nettype wire
